/* design/assert_macros.svh */
// Assertion shorthands shared by the checker files.
// Every check is sampled on clk and is off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of one property.
`define QSPE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent this cycle, consequent on the next clock.
`define QSPE_ASSERT_NEXT(label, ante, cons, msg) \
	`QSPE_ASSERT(label, (ante) |=> (cons), msg)

`endif

/* design/qspe_pkg.sv */
`default_nettype none

package qspe_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int VAL_W     = 32;
	localparam int POS_W     = 5;
	localparam int MODE_W    = 2;

	localparam logic [MODE_W-1:0] MODE_TWO_WAY   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_THREE_WAY = 2'd1;

	// one element read out of the store, ready for the output register
	typedef struct packed {
		logic                    vld;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        position;
		logic [POS_W-1:0]        equal_low;
		logic [POS_W-1:0]        equal_high;
		logic                    overflow;
		logic                    last;
	} qspe_emit_t;

endpackage

`default_nettype wire

/* design/qspe_seq.sv */
`default_nettype none

module qspe_seq import qspe_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    is_pivot,
	input  logic                    last,
	input  logic [MODE_W-1:0]       mode,
	input  logic                    out_free,
	output logic                    loading,
	output qspe_emit_t              emit
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	typedef enum logic [3:0] {
		ST_LOAD, ST_START, ST_SW_RA, ST_SW_RB, ST_SW_WA, ST_SW_WB,
		ST_P_RD, ST_P_CMP, ST_EMIT
	} state_t;

	typedef enum logic [1:0] {PH_INIT, PH_PASS1, PH_PASS2, PH_FINAL} phase_t;

	state_t                  state_q;
	phase_t                  phase_q;
	logic [CW-1:0]           cnt_q, n_q, j_q, k_q, lo_q, hi_q;
	logic [AW-1:0]           ps_q, m_q, g_q, sa_q, sb_q, rk_s1;
	logic                    ovf_q, ovfp_q, two_q, three_q, rp_s1;
	logic signed [VAL_W-1:0] pv_q, va_q;

	// element store: one write port, one registered read port
	logic signed [VAL_W-1:0] mem [DEPTH];
	logic signed [VAL_W-1:0] rdata_q;
	logic                    mem_we;
	logic [AW-1:0]           mem_wa, mem_ra;
	logic signed [VAL_W-1:0] mem_wd;

	// A read whose data is used is never issued in a cycle that writes, so it
	// always sees every earlier write; that ordering is the interlock.
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rdata_q <= mem[mem_ra];
	end

	logic          store_ok, x_eq, x_lt, adv_done, emit_go;
	logic [CW-1:0] j_nx;

	assign store_ok = (cnt_q != DEPTH_C);
	assign x_eq     = (rdata_q == pv_q);
	assign x_lt     = (rdata_q < pv_q);
	assign j_nx     = j_q + ONE_C;
	assign adv_done = (j_nx == n_q);
	assign emit_go  = !rp_s1 && (k_q != n_q) && out_free;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = cnt_q[AW-1:0];
		mem_wd = value;
		mem_ra = j_q[AW-1:0];
		case (state_q)
			ST_LOAD:  mem_we = take && store_ok;
			ST_SW_RA: mem_ra = sa_q;
			ST_SW_RB: mem_ra = sb_q;
			ST_SW_WA: begin
				mem_we = 1'b1;
				mem_wa = sa_q;
				mem_wd = rdata_q;
			end
			ST_SW_WB: begin
				mem_we = 1'b1;
				mem_wa = sb_q;
				mem_wd = va_q;
			end
			ST_EMIT:  mem_ra = k_q[AW-1:0];
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			phase_q <= PH_INIT;
			cnt_q   <= '0;
			n_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			ps_q    <= '0;
			m_q     <= '0;
			g_q     <= '0;
			sa_q    <= '0;
			sb_q    <= '0;
			rk_s1   <= '0;
			ovf_q   <= 1'b0;
			ovfp_q  <= 1'b0;
			two_q   <= 1'b0;
			three_q <= 1'b0;
			rp_s1   <= 1'b0;
			pv_q    <= '0;
			va_q    <= '0;
		end else begin
			rp_s1 <= 1'b0;
			case (state_q)
				ST_LOAD: if (take) begin
					if (store_ok) begin
						if (cnt_q == '0)
							pv_q <= value;
						if (is_pivot) begin
							pv_q <= value;
							ps_q <= cnt_q[AW-1:0];
						end
						cnt_q <= cnt_q + ONE_C;
					end else begin
						ovf_q <= 1'b1;
					end
					if (last) begin
						n_q     <= store_ok ? cnt_q + ONE_C : cnt_q;
						ovfp_q  <= ovf_q || !store_ok;
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					ps_q    <= '0;
					m_q     <= '0;
					g_q     <= '0;
					two_q   <= 1'b0;
					three_q <= (mode == MODE_THREE_WAY);
					if (mode == MODE_TWO_WAY || mode == MODE_THREE_WAY) begin
						// bring the pivot to the array start
						sa_q    <= '0;
						sb_q    <= ps_q;
						phase_q <= PH_INIT;
						state_q <= ST_SW_RA;
					end else begin
						lo_q    <= '0;
						hi_q    <= n_q - ONE_C;
						k_q     <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_SW_RA: state_q <= ST_SW_RB;
				ST_SW_RB: begin
					va_q    <= rdata_q;
					state_q <= ST_SW_WA;
				end
				ST_SW_WA: state_q <= ST_SW_WB;
				ST_SW_WB: begin
					case (phase_q)
						PH_INIT: begin
							j_q <= ONE_C;
							if (n_q == ONE_C) begin
								sa_q    <= '0;
								sb_q    <= m_q;
								phase_q <= PH_FINAL;
								state_q <= ST_SW_RA;
							end else begin
								state_q <= ST_P_RD;
							end
						end
						PH_PASS1, PH_PASS2: begin
							if (phase_q == PH_PASS1 && two_q) begin
								// three-way less: second exchange
								two_q   <= 1'b0;
								sa_q    <= m_q;
								sb_q    <= g_q;
								phase_q <= PH_PASS2;
								state_q <= ST_SW_RA;
							end else begin
								j_q <= j_nx;
								if (adv_done) begin
									sa_q    <= '0;
									sb_q    <= m_q;
									phase_q <= PH_FINAL;
									state_q <= ST_SW_RA;
								end else begin
									state_q <= ST_P_RD;
								end
							end
						end
						PH_FINAL: begin
							lo_q    <= CW'(m_q);
							hi_q    <= three_q ? CW'(g_q) : CW'(m_q);
							k_q     <= '0;
							state_q <= ST_EMIT;
						end
						default: state_q <= ST_LOAD;
					endcase
				end
				ST_P_RD: state_q <= ST_P_CMP;
				ST_P_CMP: begin
					if (three_q && x_eq) begin
						g_q     <= g_q + AW'(1);
						sa_q    <= j_q[AW-1:0];
						sb_q    <= g_q + AW'(1);
						two_q   <= 1'b0;
						phase_q <= PH_PASS1;
						state_q <= ST_SW_RA;
					end else if (three_q && x_lt) begin
						m_q     <= m_q + AW'(1);
						g_q     <= g_q + AW'(1);
						sa_q    <= g_q + AW'(1);
						sb_q    <= j_q[AW-1:0];
						two_q   <= 1'b1;
						phase_q <= PH_PASS1;
						state_q <= ST_SW_RA;
					end else if (!three_q && x_lt) begin
						m_q     <= m_q + AW'(1);
						sa_q    <= j_q[AW-1:0];
						sb_q    <= m_q + AW'(1);
						two_q   <= 1'b0;
						phase_q <= PH_PASS1;
						state_q <= ST_SW_RA;
					end else begin
						j_q <= j_nx;
						if (adv_done) begin
							sa_q    <= '0;
							sb_q    <= m_q;
							phase_q <= PH_FINAL;
							state_q <= ST_SW_RA;
						end else begin
							state_q <= ST_P_RD;
						end
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						rp_s1 <= 1'b1;
						rk_s1 <= k_q[AW-1:0];
						k_q   <= k_q + ONE_C;
					end else if (!rp_s1 && k_q == n_q) begin
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign loading = (state_q == ST_LOAD);

	always_comb begin
		emit.vld        = rp_s1;
		emit.value      = rdata_q;
		emit.position   = POS_W'(rk_s1);
		emit.equal_low  = POS_W'(lo_q);
		emit.equal_high = POS_W'(hi_q);
		emit.overflow   = ovfp_q;
		emit.last       = (CW'(rk_s1) == n_q - ONE_C);
	end

endmodule

`default_nettype wire

/* design/quicksort_partition_engine.sv */
// Quicksort partition engine.
// Input channel (valid/stall, fields value, is_pivot, last): one array element per
// transaction, one cycle each. The item with last closes the array; the engine then
// stalls its input until the partitioned array has been read out of the store.
// Result channel (res_valid/res_stall): one transaction per stored element, in
// position order, each with equal_low/equal_high, overflow and last_res.
// Work after last: a start step, an exchange bringing the pivot to the start, then
// per further element a read and a compare plus any exchanges (two-way: up to one,
// three-way: up to two), then the closing exchange. Mode 2/3 skips straight to
// readout. Each exchange reads, then writes, both entries, as the element store has
// a single read and a single write port. Readout fetches an element only once the
// prior one has landed. A stalled result holds in the output register; readout
// pauses and resumes. Input reopens in the cycle after the final result reaches the
// output register. Reset clears counters, flags and mode (two-way); the store needs
// no clearing, as only entries written for the current array are ever read.
`default_nettype none

module quicksort_partition_engine import qspe_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid,
	output logic                    stall,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    is_pivot,
	input  logic                    last,
	input  logic                    cfg_we,
	input  logic [MODE_W-1:0]       cfg_wdata,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic signed [VAL_W-1:0] value_res,
	output logic [POS_W-1:0]        position,
	output logic [POS_W-1:0]        equal_low,
	output logic [POS_W-1:0]        equal_high,
	output logic                    overflow,
	output logic                    last_res
);

	logic [MODE_W-1:0] mode_q;
	logic              loading, in_take, out_take, out_free;
	logic              res_valid_q;
	qspe_emit_t        emit;
	qspe_emit_t        res_q;

	// mode register; to be written only while idle, which the block itself does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= MODE_TWO_WAY;
		else if (cfg_we)
			mode_q <= cfg_wdata;
	end

	assign stall   = !loading;
	assign in_take = valid && !stall;

	// output register: readout only fetches when this slot frees up
	assign out_take = res_valid_q && !res_stall;
	assign out_free = !res_valid_q || out_take;

	qspe_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (in_take),
		.value   (value),
		.is_pivot(is_pivot),
		.last    (last),
		.mode    (mode_q),
		.out_free(out_free),
		.loading (loading),
		.emit    (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (emit.vld)
			res_valid_q <= 1'b1;
		else if (out_take)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit.vld)
			res_q <= emit;
	end

	assign res_valid  = res_valid_q;
	assign value_res  = res_q.value;
	assign position   = res_q.position;
	assign equal_low  = res_q.equal_low;
	assign equal_high = res_q.equal_high;
	assign overflow   = res_q.overflow;
	assign last_res   = res_q.last;

endmodule

`default_nettype wire

/* design/qspe_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module qspe_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               valid,
	input wire               stall,
	input wire               last,
	input wire               res_valid,
	input wire               res_stall,
	input wire signed [31:0] value_res,
	input wire               last_res
);

	// stalled result must hold
	`QSPE_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(value_res) && $stable(last_res), "stalled result changed")

	// mid-array readout keeps the input closed
	`QSPE_ASSERT(a_busy_emit, (res_valid && !last_res) |-> stall, "input open during readout")

	// closing transaction closes the input for the partition work or readout
	`QSPE_ASSERT_NEXT(a_last_busy, valid && !stall && last, stall, "input open after array end")

endmodule

bind quicksort_partition_engine qspe_checker u_qspe_checker (.*);

`default_nettype wire

/* verif/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import qspe_pkg::*;

	// Codes for the two settings that leave the array as loaded.
	localparam logic [MODE_W-1:0] MODE_KEEP     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_KEEP_ALT = 2'd3;

	localparam int DEPTH          = DEPTH_DEF;
	localparam int IDLE_PCT       = 19;
	// Quiet time after the last result before a mode write or the final verdict.
	localparam int SETTLE_CYCLES  = 40;
	localparam int HOLD_CYCLES    = 400;
	localparam int RANDOM_ITEMS   = 40;

	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	// One element as it should leave the engine.
	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        position;
		logic [POS_W-1:0]        equal_low;
		logic [POS_W-1:0]        equal_high;
		logic                    overflow;
		logic                    last;
	} placed_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    valid = 1'b0;
	logic                    stall;
	logic signed [VAL_W-1:0] value = '0;
	logic                    is_pivot = 1'b0;
	logic                    last = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [MODE_W-1:0]       cfg_wdata = '0;
	logic                    res_valid;
	logic                    res_stall = 1'b0;
	logic signed [VAL_W-1:0] value_res;
	logic [POS_W-1:0]        position;
	logic [POS_W-1:0]        equal_low;
	logic [POS_W-1:0]        equal_high;
	logic                    overflow;
	logic                    last_res;

	// Shadow of the engine: loaded elements, pivot choice, dropped flag, mode.
	logic signed [VAL_W-1:0] held [DEPTH];
	int                      held_count = 0;
	int                      pivot_at = 0;
	bit                      dropped = 1'b0;
	logic [MODE_W-1:0]       mode_now = MODE_TWO_WAY;
	placed_t                 placed_q [$];

	int failures = 0;
	int items_sent = 0;
	// calm = 1 turns off random idling on both channels.
	bit calm = 1'b0;
	// Long receiver hold-off: the test bumps hold_ask, the receiver serves it.
	int hold_ask = 0;
	int hold_granted = 0;
	int hold_left = 0;

	quicksort_partition_engine #(
		.DEPTH(DEPTH)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (valid),
		.stall      (stall),
		.value      (value),
		.is_pivot   (is_pivot),
		.last       (last),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.value_res  (value_res),
		.position   (position),
		.equal_low  (equal_low),
		.equal_high (equal_high),
		.overflow   (overflow),
		.last_res   (last_res)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------------
	// Partition predictor
	// ---------------------------------------------------------------------
	function automatic void swap_held(int a, int b);
		logic signed [VAL_W-1:0] t;
		t = held[a];
		held[a] = held[b];
		held[b] = t;
	endfunction

	// Takes one accepted element; on the closing element it partitions the
	// shadow array and queues every element the engine should hand out.
	function automatic void absorb_element(logic signed [VAL_W-1:0] v, logic piv, logic fin);
		int lo, hi, m, g, n;
		logic signed [VAL_W-1:0] pv;
		placed_t p;
		if (held_count < DEPTH) begin
			held[held_count] = v;
			if (piv)
				pivot_at = held_count;
			held_count++;
		end else begin
			// store full: element is lost, its pivot mark too
			dropped = 1'b1;
		end
		if (!fin)
			return;
		n = held_count;
		if (mode_now == MODE_TWO_WAY || mode_now == MODE_THREE_WAY) begin
			// pivot goes to slot 0 first, both passes compare against it
			swap_held(0, pivot_at);
			m = 0;
			g = 0;
			if (mode_now == MODE_TWO_WAY) begin
				for (int j = 0; j < n; j++) begin
					if (held[j] < held[0]) begin
						swap_held(j, m + 1);
						m++;
					end
				end
				g = m;
			end else begin
				// [1..m] less, [m+1..g] equal, rest greater
				for (int j = 1; j < n; j++) begin
					pv = held[0];
					if (held[j] == pv) begin
						g++;
						swap_held(j, g);
					end else if (held[j] < pv) begin
						m++;
						g++;
						swap_held(g, j);
						swap_held(m, g);
					end
				end
			end
			swap_held(0, m);
			lo = m;
			hi = g;
		end else begin
			lo = 0;
			hi = n - 1;
		end
		for (int k = 0; k < n; k++) begin
			p.value      = held[k];
			p.position   = POS_W'(k);
			p.equal_low  = POS_W'(lo);
			p.equal_high = POS_W'(hi);
			p.overflow   = dropped;
			p.last       = (k + 1 == n);
			placed_q.push_back(p);
		end
		held_count = 0;
		pivot_at = 0;
		dropped = 1'b0;
	endfunction

	// ---------------------------------------------------------------------
	// Result side: random stall, long hold-off on request, field check
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_left != 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_granted != hold_ask) begin
			res_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_granted <= hold_ask;
		end else begin
			res_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	function automatic void compare_field(string name, logic signed [63:0] want,
			logic signed [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			failures++;
		end
	endfunction

	// Handshake signals are stable mid-cycle, so the check runs on the falling
	// edge ahead of the rising edge that completes the transaction.
	always @(negedge clk) begin : result_check
		placed_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (placed_q.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual value %0d position %0d",
					$time, value_res, position);
				failures++;
			end else begin
				want = placed_q.pop_front();
				compare_field("value_res", want.value, value_res);
				compare_field("position", want.position, position);
				compare_field("equal_low", want.equal_low, equal_low);
				compare_field("equal_high", want.equal_high, equal_high);
				compare_field("overflow", want.overflow, overflow);
				compare_field("last_res", want.last, last_res);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Input side
	// ---------------------------------------------------------------------
	// Called at a rising edge; returns at the edge that took the transaction.
	task automatic send_element(input logic signed [VAL_W-1:0] v, input logic piv,
			input logic fin);
		bit took;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			valid <= 1'b0;
			@(posedge clk);
		end
		valid <= 1'b1;
		value <= v;
		is_pivot <= piv;
		last <= fin;
		do begin
			@(negedge clk);
			took = !stall;
			@(posedge clk);
		end while (!took);
		absorb_element(v, piv, fin);
		items_sent++;
	endtask

	// Bit k of marks flags element k as a pivot candidate; last closes the list.
	task automatic send_array(input logic signed [VAL_W-1:0] vals [$], input bit [63:0] marks);
		foreach (vals[k])
			send_element(vals[k], marks[k], k == vals.size() - 1);
	endtask

	// Wait until every queued element has come out, then let the engine settle.
	task automatic drain();
		valid <= 1'b0;
		while (placed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mode changes only while the engine is idle.
	task automatic set_mode(input logic [MODE_W-1:0] m);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		mode_now = m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mix of tiny values (many pivot ties), extremes and full-range values.
	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(4))
			0: return VAL_W'(int'($urandom_range(6)) - 3);
			1: begin
				case ($urandom_range(4))
					0: return VAL_MIN;
					1: return VAL_MAX;
					2: return '0;
					3: return '1;
					default: return VAL_W'(1);
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	// Mostly short arrays, a few that reach or pass the store depth.
	function automatic int pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return $urandom_range(8, 1);
		if (r < 95)
			return $urandom_range(DEPTH - 1, 9);
		return $urandom_range(DEPTH + 3, DEPTH);
	endfunction

	task automatic random_array(input int len);
		for (int k = 0; k < len; k++)
			send_element(pick_value(), $urandom_range(99) < 12, k == len - 1);
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------
	// No mode write yet: reset value must give the two-way pass.
	task automatic test_default_mode();
		send_array('{32'sd5, -32'sd3, 32'sd7, 32'sd5, 32'sd0}, 64'b01000);
	endtask

	task automatic test_two_way();
		set_mode(MODE_TWO_WAY);
		send_array('{VAL_MIN, VAL_MAX, 32'sd0, -32'sd1, 32'sd1}, 64'b00100);
		// single element, marked
		send_array('{VAL_MAX}, 64'b1);
		// two marks: the later one wins
		send_array('{32'sd3, 32'sd1, 32'sd4, 32'sd1, 32'sd5}, 64'b01001);
	endtask

	task automatic test_three_way();
		set_mode(MODE_THREE_WAY);
		// no mark: first element is the pivot, with several ties
		send_array('{32'sd2, -32'sd7, 32'sd2, 32'sd2, 32'sd9, -32'sd7, 32'sd2}, 64'b0);
		send_array('{VAL_MIN, VAL_MIN, VAL_MAX, VAL_MIN}, 64'b1000);
	endtask

	task automatic test_unchanged_modes();
		set_mode(MODE_KEEP);
		send_array('{32'sd9, -32'sd4, 32'sd1}, 64'b010);
		set_mode(MODE_KEEP_ALT);
		send_array('{VAL_MAX, 32'sd0, VAL_MIN}, 64'b100);
	endtask

	// Exactly full store, then a store overrun whose closing element is lost
	// together with its pivot mark, then an overrun in a mode that keeps the order.
	task automatic test_full_store();
		set_mode(MODE_TWO_WAY);
		random_array(DEPTH);
		set_mode(MODE_THREE_WAY);
		for (int k = 0; k < DEPTH + 2; k++)
			send_element(pick_value(), k == DEPTH + 1 || k == 5, k == DEPTH + 1);
		set_mode(MODE_KEEP);
		random_array(DEPTH + 1);
	endtask

	// Receiver holds off while the sender keeps offering two arrays, so the
	// output register fills and the engine pushes back on its input.
	task automatic test_backpressure();
		set_mode(MODE_THREE_WAY);
		hold_ask <= hold_ask + 1;
		random_array(12);
		random_array(6);
	endtask

	task automatic test_random_arrays();
		int start;
		start = items_sent;
		calm = 1'b1;
		while (items_sent - start < RANDOM_ITEMS) begin
			// first stretch runs with no idling on either side
			if (items_sent - start >= 20)
				calm = 1'b0;
			if ($urandom_range(5) == 0)
				set_mode(MODE_W'($urandom_range(3)));
			random_array(pick_length());
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_mode();
		test_two_way();
		test_three_way();
		test_unchanged_modes();
		test_full_store();
		test_backpressure();
		test_random_arrays();

		drain();
		if (placed_q.size() != 0)
			failures++;
		if (failures == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/qspe_pkg.sv
design/qspe_seq.sv
design/quicksort_partition_engine.sv
design/qspe_checker.sv
verif/testbench.sv
